// ===== hdl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int SLOT_W  = 7;
  localparam int DIGIT_W = 4;
  localparam int DIV_STEPS = KEY_W / DIGIT_W;

  localparam logic [SLOT_W-1:0] SLOTS_RESET = 7'd64;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;
  localparam logic [2:0] ST_ABSENT   = 3'd6;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [31:0] key;
    logic [15:0]       value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_value;
    logic [6:0]  entries_used;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       set_home;
    logic       adv_idx;
    logic       write_new;
    logic       write_upd;
    logic       clear_idx;
    logic       set_nx;
    logic       nx_to_idx;
    logic       ld_move;
    logic       adv_nx;
    logic       emit;
    logic       emit_found;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       occ_here;
    logic       key_match;
    logic       at_start;
    logic       walk_end;
    logic [1:0] act;
  } sts_t;

endpackage

// ===== hdl/lpht_mod.sv =====
module lpht_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [6:0]  modulus,
  output logic        done,
  output logic [6:0]  rem
);

  logic [31:0] dvd_r;
  logic [6:0]  rem_r, rem_nxt;
  logic [2:0]  cnt_r;
  logic        run_r, done_r;
  logic [31:0] mag;

  // magnitude of the most negative key wraps to 2^31, which is what we want
  assign mag = dividend[31] ? (32'd0 - dividend) : dividend;

  always_comb begin
    logic [7:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < lpht_pkg::DIGIT_W; i++) begin
      t = {rem_nxt, dvd_r[31-i]};
      if (t >= {1'b0, modulus}) t = t - {1'b0, modulus};
      rem_nxt = t[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(lpht_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= mag;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= dvd_r << lpht_pkg::DIGIT_W;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/lpht_dp.sv =====
module lpht_dp #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lpht_pkg::in_t   in_data,
  input  logic            cfg_valid,
  input  logic [6:0]      cfg_data,
  input  lpht_pkg::cmd_t  cmd,
  output lpht_pkg::sts_t  sts,
  output logic            out_valid,
  output lpht_pkg::out_t  out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [6:0]        slots_r;
  logic [6:0]        n;
  logic [1:0]        act_r;
  logic [31:0]       key_r;
  logic [15:0]       val_r;
  logic [IW-1:0]     idx_r, start_r, nx_r, idx_inc, nx_inc;
  logic [6:0]        steps_r;
  logic [DEPTH-1:0]  occ_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [31:0]       keys [DEPTH];
  logic [15:0]       vals [DEPTH];
  logic [31:0]       rd_key_r;
  logic [15:0]       rd_val_r;
  logic              out_valid_r;
  lpht_pkg::out_t    out_data_r;
  logic              div_done;
  logic [6:0]        rem;
  logic [7:0]        idx_p1, nx_p1, cnt_ext;

  always_comb begin
    if (slots_r == 7'd0) n = 7'd1;
    else if ({1'b0, slots_r} > 8'(DEPTH)) n = 7'(DEPTH);
    else n = slots_r;
  end

  assign idx_p1  = 8'(idx_r) + 8'd1;
  assign nx_p1   = 8'(nx_r) + 8'd1;
  assign idx_inc = (idx_p1 == {1'b0, n}) ? '0 : idx_p1[IW-1:0];
  assign nx_inc  = (nx_p1 == {1'b0, n}) ? '0 : nx_p1[IW-1:0];

  lpht_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load | cmd.ld_move),
    .dividend (cmd.load ? in_data.key : rd_key_r),
    .modulus  (n),
    .done     (div_done),
    .rem      (rem)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.write_new) count_nxt = count_r + CW'(1);
    else if ((cmd.clear_idx | cmd.ld_move) && count_r != '0) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= lpht_pkg::SLOTS_RESET;
      occ_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) slots_r <= cfg_data;
      if (cmd.write_new) occ_r[idx_r] <= 1'b1;
      if (cmd.clear_idx | cmd.ld_move) occ_r[idx_r] <= 1'b0;
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      key_r <= in_data.key;
      val_r <= in_data.value;
    end else if (cmd.ld_move) begin
      key_r <= rd_key_r;
      val_r <= rd_val_r;
    end
    if (cmd.set_home) begin
      idx_r   <= rem[IW-1:0];
      start_r <= rem[IW-1:0];
    end else if (cmd.adv_idx) begin
      idx_r <= idx_inc;
    end else if (cmd.nx_to_idx) begin
      idx_r <= nx_r;
    end
    if (cmd.set_nx) begin
      nx_r    <= idx_inc;
      steps_r <= n - 7'd1;
    end else if (cmd.adv_nx) begin
      nx_r    <= nx_inc;
      steps_r <= steps_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_new) keys[idx_r] <= key_r;
    if (cmd.write_new | cmd.write_upd) vals[idx_r] <= val_r;
    rd_key_r <= keys[idx_r];
    rd_val_r <= vals[idx_r];
  end

  assign cnt_ext = 8'(count_nxt);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.status       <= cmd.code;
      out_data_r.found_value  <= cmd.emit_found ? rd_val_r : 16'd0;
      out_data_r.entries_used <= cnt_ext[6:0];
    end
  end

  assign sts.div_done  = div_done;
  assign sts.occ_here  = occ_r[idx_r];
  assign sts.key_match = (rd_key_r == key_r);
  assign sts.at_start  = (idx_inc == start_r);
  assign sts.walk_end  = (steps_r == 7'd0) || !occ_r[nx_r];
  assign sts.act       = act_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/lpht_ctrl.sv =====
module lpht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  lpht_pkg::sts_t  sts,
  output lpht_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_MVRD  = 3'd5;
  localparam logic [2:0] S_MVLD  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       moving_r, moving_nxt;
  logic [1:0] op;

  // a moved entry is re-placed with insert rules
  assign op = moving_r ? lpht_pkg::ACT_INSERT : sts.act;

  always_comb begin
    state_nxt  = state_r;
    moving_nxt = moving_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          moving_nxt = 1'b0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (op inside {lpht_pkg::ACT_INSERT, lpht_pkg::ACT_FIND,
                         lpht_pkg::ACT_REMOVE}) begin
            cmd.set_home = 1'b1;
            state_nxt    = S_PROBE;
          end else begin
            cmd.emit  = 1'b1;
            cmd.code  = lpht_pkg::ST_NOTFOUND;
            state_nxt = S_IDLE;
          end
        end
      end
      S_PROBE: begin
        if (sts.occ_here) begin
          state_nxt = S_CMP;
        end else begin
          case (op)
            lpht_pkg::ACT_INSERT: begin
              cmd.write_new = 1'b1;
              if (moving_r) begin
                cmd.adv_nx = 1'b1;
                state_nxt  = S_WALK;
              end else begin
                cmd.emit  = 1'b1;
                cmd.code  = lpht_pkg::ST_INSERTED;
                state_nxt = S_IDLE;
              end
            end
            lpht_pkg::ACT_FIND: begin
              cmd.emit  = 1'b1;
              cmd.code  = lpht_pkg::ST_NOTFOUND;
              state_nxt = S_IDLE;
            end
            default: begin
              cmd.emit  = 1'b1;
              cmd.code  = lpht_pkg::ST_ABSENT;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          case (op)
            lpht_pkg::ACT_INSERT: begin
              cmd.write_upd = 1'b1;
              if (moving_r) begin
                cmd.adv_nx = 1'b1;
                state_nxt  = S_WALK;
              end else begin
                cmd.emit  = 1'b1;
                cmd.code  = lpht_pkg::ST_UPDATED;
                state_nxt = S_IDLE;
              end
            end
            lpht_pkg::ACT_FIND: begin
              cmd.emit       = 1'b1;
              cmd.emit_found = 1'b1;
              cmd.code       = lpht_pkg::ST_FOUND;
              state_nxt      = S_IDLE;
            end
            default: begin
              cmd.clear_idx = 1'b1;
              cmd.set_nx    = 1'b1;
              state_nxt     = S_WALK;
            end
          endcase
        end else if (sts.at_start) begin
          case (op)
            lpht_pkg::ACT_INSERT: begin
              if (moving_r) begin
                cmd.adv_nx = 1'b1;
                state_nxt  = S_WALK;
              end else begin
                cmd.emit  = 1'b1;
                cmd.code  = lpht_pkg::ST_FULL;
                state_nxt = S_IDLE;
              end
            end
            lpht_pkg::ACT_FIND: begin
              cmd.emit  = 1'b1;
              cmd.code  = lpht_pkg::ST_NOTFOUND;
              state_nxt = S_IDLE;
            end
            default: begin
              cmd.emit  = 1'b1;
              cmd.code  = lpht_pkg::ST_ABSENT;
              state_nxt = S_IDLE;
            end
          endcase
        end else begin
          cmd.adv_idx = 1'b1;
          state_nxt   = S_PROBE;
        end
      end
      S_WALK: begin
        if (sts.walk_end) begin
          cmd.emit  = 1'b1;
          cmd.code  = lpht_pkg::ST_REMOVED;
          state_nxt = S_IDLE;
        end else begin
          cmd.nx_to_idx = 1'b1;
          state_nxt     = S_MVRD;
        end
      end
      S_MVRD: state_nxt = S_MVLD;
      S_MVLD: begin
        // take the entry out and hash its key again
        cmd.ld_move = 1'b1;
        moving_nxt  = 1'b1;
        state_nxt   = S_DIV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      moving_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      moving_r <= moving_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------
// input    | start, busy, in_data           | taken when start & !busy
// result   | out_valid, out_data            | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data | written when valid & ready
//
// An item takes the key modulo (8 radix-16 steps), then a memory read and compare
// per occupied slot probed; the empty slot ending the probe needs only the probe
// state. The result is on the port in the cycle after it is issued. Remove adds
// walk, read and load states and a fresh modulo and probe per entry moved; a last
// walk state ends the walk. Reset clears occupancy bits at once; no clearing pass.
// Results cannot be held off; the next item may start while one is on the port.
module linear_probe_hash_table #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lpht_pkg::in_t  in_data,
  output logic           out_valid,
  output lpht_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [6:0]     cfg_data
);

  // the slot count register reaches 127 at most
  localparam int DEPTH = (SLOTS < 128) ? SLOTS : 128;

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lpht_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_linear_probe_hash_table.sv =====
module tb_linear_probe_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int WATCH_LIMIT = 200000;

  logic clk, rst_n, start, busy, out_valid, cfg_valid, cfg_ready;
  lpht_pkg::in_t in_data;
  lpht_pkg::out_t out_data;
  logic [6:0] cfg_data;

  linear_probe_hash_table #(.SLOTS(NSLOT)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow table
  logic [31:0] tbl_key [NSLOT];
  logic [15:0] tbl_val [NSLOT];
  bit          tbl_occ [NSLOT];
  int unsigned tbl_count;
  logic [6:0]  slots_reg;

  lpht_pkg::out_t pending_q[$];
  int   errors;
  int   stall_cycles;
  bit   quiet;
  int   key_pool[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned live_slots();
    int unsigned n;
    n = slots_reg;
    if (n < 1) n = 1;
    if (n > NSLOT) n = NSLOT;
    return n;
  endfunction

  function automatic int unsigned home_of(logic [31:0] k, int unsigned n);
    logic [31:0] mag;
    mag = k[31] ? (32'd0 - k) : k;
    return mag % n;
  endfunction

  function automatic logic [2:0] table_put(logic [31:0] k, logic [15:0] v,
                                           int unsigned n);
    int unsigned idx, first;
    idx = home_of(k, n);
    first = idx;
    while (tbl_occ[idx]) begin
      if (tbl_key[idx] == k) begin
        tbl_val[idx] = v;
        return lpht_pkg::ST_UPDATED;
      end
      idx = (idx + 1) % n;
      if (idx == first) return lpht_pkg::ST_FULL;
    end
    tbl_key[idx] = k;
    tbl_val[idx] = v;
    tbl_occ[idx] = 1;
    tbl_count++;
    return lpht_pkg::ST_INSERTED;
  endfunction

  function automatic bit table_locate(logic [31:0] k, int unsigned n,
                                      output int unsigned at);
    int unsigned idx, first;
    idx = home_of(k, n);
    first = idx;
    at = 0;
    while (tbl_occ[idx]) begin
      if (tbl_key[idx] == k) begin
        at = idx;
        return 1;
      end
      idx = (idx + 1) % n;
      if (idx == first) break;
    end
    return 0;
  endfunction

  function automatic lpht_pkg::out_t predict_op(lpht_pkg::in_t it);
    lpht_pkg::out_t r;
    int unsigned n, at, nx, steps;
    logic [31:0] mk;
    logic [15:0] mv;
    logic [2:0] dummy;
    n = live_slots();
    r = '0;
    r.status = lpht_pkg::ST_NOTFOUND;
    if (it.action == lpht_pkg::ACT_INSERT) begin
      r.status = table_put(it.key, it.value, n);
    end else if (it.action == lpht_pkg::ACT_FIND) begin
      if (table_locate(it.key, n, at)) begin
        r.status = lpht_pkg::ST_FOUND;
        r.found_value = tbl_val[at];
      end
    end else if (it.action == lpht_pkg::ACT_REMOVE) begin
      if (!table_locate(it.key, n, at)) begin
        r.status = lpht_pkg::ST_ABSENT;
      end else begin
        tbl_occ[at] = 0;
        if (tbl_count > 0) tbl_count--;
        nx = (at + 1) % n;
        steps = n - 1;
        while (steps > 0 && tbl_occ[nx]) begin
          mk = tbl_key[nx];
          mv = tbl_val[nx];
          tbl_occ[nx] = 0;
          if (tbl_count > 0) tbl_count--;
          dummy = table_put(mk, mv, n);
          nx = (nx + 1) % n;
          steps--;
        end
        r.status = lpht_pkg::ST_REMOVED;
      end
    end
    r.entries_used = tbl_count[6:0];
    return r;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] act, logic [31:0] k, logic [15:0] v);
    lpht_pkg::in_t it;
    lpht_pkg::in_t junk;
    idle_burst();
    it.action = act;
    it.key = k;
    it.value = v;
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_q.push_back(predict_op(it));
    @(negedge clk);
    junk.action = 2'($urandom);
    junk.key = $urandom;
    junk.value = 16'($urandom);
    start <= 1'b0;
    in_data <= junk;
    // the block stays busy well past this edge
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    // last result has issued; the block is already idle by then
    repeat (4) @(negedge clk);
  endtask

  task automatic write_slots(logic [6:0] s);
    drain();
    cfg_data <= s;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    slots_reg = s;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= 7'($urandom);
  endtask

  always @(posedge clk) begin
    lpht_pkg::out_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_data !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d fv=%h n=%0d got st=%0d fv=%h n=%0d",
                     exp_r.status, exp_r.found_value, exp_r.entries_used,
                     out_data.status, out_data.found_value, out_data.entries_used);
        end
      end
    end
  end

  // watchdog: count cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCH_LIMIT) begin
        $display("tb_linear_probe_hash_table: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && key_pool.size() != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (sel == 6) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic test_directed();
    write_slots(7'd64);
    send_op(lpht_pkg::ACT_FIND, 32'd5, 16'hFFFF);
    send_op(lpht_pkg::ACT_REMOVE, 32'd5, 16'h0);
    send_op(lpht_pkg::ACT_INSERT, 32'h8000_0000, 16'hFFFF);
    send_op(lpht_pkg::ACT_INSERT, 32'h7FFF_FFFF, 16'h0000);
    send_op(lpht_pkg::ACT_INSERT, 32'hFFFF_FFFF, 16'h1234);
    send_op(lpht_pkg::ACT_INSERT, 32'd1, 16'h5555);
    send_op(lpht_pkg::ACT_INSERT, 32'd65, 16'hAAAA);
    send_op(lpht_pkg::ACT_INSERT, 32'd1, 16'h0F0F);
    send_op(lpht_pkg::ACT_FIND, 32'h8000_0000, 16'h0);
    send_op(lpht_pkg::ACT_FIND, 32'd65, 16'h0);
    send_op(lpht_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 16'h0);
    send_op(lpht_pkg::ACT_FIND, 32'd65, 16'h0);
    send_op(lpht_pkg::ACT_UNUSED, 32'd1, 16'hFFFF);
    // shrink with entries beyond the new range
    write_slots(7'd2);
    send_op(lpht_pkg::ACT_INSERT, 32'd2, 16'h1);
    send_op(lpht_pkg::ACT_INSERT, 32'd3, 16'h2);
    send_op(lpht_pkg::ACT_INSERT, 32'd4, 16'h3);
    send_op(lpht_pkg::ACT_REMOVE, 32'd2, 16'h0);
    write_slots(7'd0);
    send_op(lpht_pkg::ACT_INSERT, 32'd9, 16'h9);
    send_op(lpht_pkg::ACT_INSERT, 32'd10, 16'hA);
    send_op(lpht_pkg::ACT_FIND, 32'd9, 16'h0);
    write_slots(7'd127);
    send_op(lpht_pkg::ACT_FIND, 32'd1, 16'h0);
    send_op(lpht_pkg::ACT_REMOVE, 32'd1, 16'h0);
  endtask

  task automatic test_random_phase(logic [6:0] s, int count);
    int r;
    logic [31:0] k;
    logic [1:0] act;
    write_slots(s);
    key_pool.delete();
    repeat (8) key_pool.push_back($urandom_range(0, 300) - 150);
    repeat (count) begin
      r = $urandom_range(0, 99);
      act = r < 50 ? lpht_pkg::ACT_INSERT :
            (r < 75 ? lpht_pkg::ACT_FIND :
             (r < 97 ? lpht_pkg::ACT_REMOVE : lpht_pkg::ACT_UNUSED));
      k = pick_key();
      if (act == lpht_pkg::ACT_INSERT && key_pool.size() < 40 && $urandom_range(0, 1))
        key_pool.push_back(k);
      send_op(act, k, 16'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    quiet = 0;
    slots_reg = lpht_pkg::SLOTS_RESET;
    tbl_count = 0;
    foreach (tbl_occ[i]) begin
      tbl_occ[i] = 0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    rst_n = 0;
    start = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed();
    test_random_phase(7'd8, 250);
    test_random_phase(7'd1, 100);
    test_random_phase(7'd64, 300);
    test_random_phase(7'd17, 250);
    quiet = 1;
    test_random_phase(7'd5, 250);
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_linear_probe_hash_table: clean");
    end else begin
      $display("tb_linear_probe_hash_table: errors");
    end
    $finish;
  end
endmodule
